// ===== sv/afp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afp_pkg
// shared types, formats and the degree-scaled arctangent table
// ----------------------------------------------------------------------------
package afp_pkg;

    localparam int TABLE_LEN = 24;   // stages the table covers
    localparam int PRESHIFT  = 24;   // left shift of |dx| and |dy| into x and y
    localparam int FRAC_BITS = 16;   // fraction bits of the angle accumulator
    localparam int MAG_W     = 16;   // width of |dx| and |dy|
    localparam int XW        = 44;   // cordic x and y, signed, with headroom for gain
    localparam int ZW        = 24;   // angle accumulator, signed degrees q16
    localparam int DEG_W     = 7;    // whole-degree result
    localparam int COORD_W   = 16;   // one coordinate
    localparam int IN_W      = 4 * COORD_W;
    localparam int OUT_W     = 16;   // angle, left, below, zero padded

    localparam logic [DEG_W-1:0] DEG_ZERO  = DEG_W'(0);
    localparam logic [DEG_W-1:0] DEG_DIAG  = DEG_W'(45);
    localparam logic [DEG_W-1:0] DEG_RIGHT = DEG_W'(90);

    // side info that rides along the cell chain untouched
    typedef struct packed {
        logic             left;
        logic             below;
        logic             forced;      // angle settled before the chain
        logic [DEG_W-1:0] forced_deg;
    } t_side;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        t_side                side;
    } t_pipe;

    // round(atan(2^-i) * 180/pi * 2^16)
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = ZW'(0);
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/angle_and_direction_from_points.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// angle_and_direction_from_points
// whole-degree first-quadrant arctangent and direction flags for a point pair
// ----------------------------------------------------------------------------
// stages: one input stage, one cell per micro-rotation, one output register
// throughput: one item per cycle while the output side takes results; every cell
//   holds its own item, so the chain keeps filling while a finished item waits at the output
// reset: synchronous, active low; clears the valid flags only, data regs keep
//   whatever they hold
// ----------------------------------------------------------------------------
module angle_and_direction_from_points #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input points
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // target_x, target_y, origin_x, origin_y
    // result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // angle_degrees[6:0], target_left, target_below, 0
);
    import afp_pkg::*;

    // stage count outside the table range folds onto its ends
    localparam int NUM_CELLS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN :
                               (CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES;

    // chain links: link g feeds cell g, link NUM_CELLS feeds the output stage
    logic  c_valid [NUM_CELLS+1];
    logic  c_ready [NUM_CELLS+1];
    t_pipe c_data  [NUM_CELLS+1];

    // differences, flags, early answers for the axis and diagonal cases
    afp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_data  (c_data[0])
    );

    // micro-rotation cells, each with its own shift and table angle
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        afp_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    // degree floor, clamp and output register
    afp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[NUM_CELLS]),
        .o_ready (c_ready[NUM_CELLS]),
        .i_data  (c_data[NUM_CELLS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    // the angle never leaves its quadrant
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'd90))
        else $error("angle above 90 degrees");

    // input only stalls when the whole chain is full behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the output side is free");

    // padding bits above the flags stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0))
        else $error("nonzero padding in result");

endmodule
`default_nettype wire

// ===== sv/afp_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afp_prep
// differences, magnitudes, direction flags and the trivial angles
// ----------------------------------------------------------------------------
module afp_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [afp_pkg::IN_W-1:0]     i_data,   // target_x, target_y, origin_x, origin_y
    output logic                         o_valid,
    input  logic                         i_ready,
    output afp_pkg::t_pipe               o_data
);
    import afp_pkg::*;

    logic signed [COORD_W-1:0] tx, ty, ox, oy;
    logic signed [COORD_W:0]   dx, dy;
    logic [COORD_W:0]          adx, ady;
    logic [MAG_W-1:0]          ax, ay;
    t_pipe                     n_data;
    t_pipe                     r_data;
    logic                      r_valid;

    assign tx = i_data[0*COORD_W +: COORD_W];
    assign ty = i_data[1*COORD_W +: COORD_W];
    assign ox = i_data[2*COORD_W +: COORD_W];
    assign oy = i_data[3*COORD_W +: COORD_W];

    assign dx  = (COORD_W+1)'(tx) - (COORD_W+1)'(ox);
    assign dy  = (COORD_W+1)'(ty) - (COORD_W+1)'(oy);
    assign adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    assign ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
    // magnitude of a 17-bit difference never exceeds 65535
    assign ax  = adx[MAG_W-1:0];
    assign ay  = ady[MAG_W-1:0];

    always_comb begin
        n_data.x               = XW'({ax, {PRESHIFT{1'b0}}});
        n_data.y               = XW'({ay, {PRESHIFT{1'b0}}});
        n_data.z               = '0;
        n_data.side.left       = (tx < ox);
        n_data.side.below      = (ty > oy);
        n_data.side.forced     = 1'b1;
        n_data.side.forced_deg = DEG_ZERO;
        if (ax == '0) begin
            n_data.side.forced_deg = (ay == '0) ? DEG_ZERO : DEG_RIGHT;
        end else if (ay == '0) begin
            n_data.side.forced_deg = DEG_ZERO;
        end else if (ax == ay) begin
            n_data.side.forced_deg = DEG_DIAG;
        end else begin
            n_data.side.forced     = 1'b0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== sv/afp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afp_cell
// one vectoring micro-rotation with its own holding register
// ----------------------------------------------------------------------------
module afp_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  afp_pkg::t_pipe i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output afp_pkg::t_pipe o_data
);
    import afp_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = atan_deg(STAGE);

    logic signed [XW-1:0] v_x, v_y, xs, ys;
    logic signed [ZW-1:0] v_z;
    t_pipe                n_data;
    t_pipe                r_data;
    logic                 r_valid;

    assign v_x = i_data.x;
    assign v_y = i_data.y;
    assign v_z = i_data.z;
    // arithmetic shift floors, as the rotation requires
    assign xs  = v_x >>> STAGE;
    assign ys  = v_y >>> STAGE;

    always_comb begin
        n_data.side = i_data.side;
        if (!v_y[XW-1]) begin
            n_data.x = v_x + ys;
            n_data.y = v_y - xs;
            n_data.z = v_z + ANGLE;
        end else begin
            n_data.x = v_x - ys;
            n_data.y = v_y + xs;
            n_data.z = v_z - ANGLE;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== sv/afp_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afp_out
// whole degrees from the accumulator, clamp, and the output register
// ----------------------------------------------------------------------------
module afp_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  afp_pkg::t_pipe            i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [afp_pkg::OUT_W-1:0] o_data   // angle_degrees[6:0], target_left, target_below
);
    import afp_pkg::*;

    logic signed [ZW-1:0]      v_z;
    logic [DEG_W-1:0]          whole;
    logic [DEG_W-1:0]          deg;
    logic [OUT_W-1:0]          r_data;
    logic                      r_valid;

    assign v_z   = i_data.z;
    assign whole = v_z[FRAC_BITS +: DEG_W];

    always_comb begin
        if (i_data.side.forced) begin
            deg = i_data.side.forced_deg;
        end else if (v_z[ZW-1]) begin
            deg = DEG_ZERO;
        end else if (whole > DEG_RIGHT) begin
            deg = DEG_RIGHT;
        end else begin
            deg = whole;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= OUT_W'({i_data.side.below, i_data.side.left, deg});
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire
